// ===== rtl/smi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_pkg: shared types and codes for the int32 stack machine executor
// Instruction kinds, error codes and controller states.
// ----------------------------------------------------------------------------
package smi_pkg;

	typedef enum logic [4:0] {
		K_NOP    = 5'd0,
		K_PUSHC  = 5'd1,
		K_LDARG  = 5'd2,
		K_LDLOC  = 5'd3,
		K_STLOC  = 5'd4,
		K_ADD    = 5'd5,
		K_SUB    = 5'd6,
		K_MUL    = 5'd7,
		K_DIV    = 5'd8,
		K_MOD    = 5'd9,
		K_NEG    = 5'd10,
		K_AND    = 5'd11,
		K_OR     = 5'd12,
		K_XOR    = 5'd13,
		K_BITNOT = 5'd14,
		K_LOGNOT = 5'd15,
		K_EQ     = 5'd16,
		K_NE     = 5'd17,
		K_LT     = 5'd18,
		K_LE     = 5'd19,
		K_GT     = 5'd20,
		K_GE     = 5'd21
	} kind_t;

	typedef enum logic [2:0] {
		ERR_OK    = 3'd0,
		ERR_UNDER = 3'd1,
		ERR_OVER  = 3'd2,
		ERR_DIV0  = 3'd3,
		ERR_INDEX = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_WRITE,
		ST_TOP,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/stack_machine_int32_executor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_int32_executor_top: int32 bytecode stack machine executor
// Runs one decoded instruction per start on an operand stack and a local
// store held in synchronous memories.
// ----------------------------------------------------------------------------
// One instruction is taken per start while busy is low. Its result shows on
// top_value, stack_depth and error_code while done is high for one cycle, and
// busy drops the cycle after done. After the accepting edge an instruction
// passes through read, the two operand phases, write-back, top read and done;
// one that faults, or divides by zero, skips the write-back. Div and mod add a
// radix-2 divider pass before the write-back. A new transaction is taken only
// once busy has dropped. After reset the local store is cleared, one entry per
// cycle, with busy high; configuration writes are taken throughout.
module stack_machine_int32_executor_top
	import smi_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int LOCAL_COUNT = 16,
	parameter int ARG_COUNT   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  kind,
	input  wire logic signed [31:0] immediate,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic signed [31:0] top_value,
	output logic [4:0]       stack_depth,
	output logic [2:0]       error_code
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int LAW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
	localparam int NARG = (ARG_COUNT < 4) ? ARG_COUNT : 4;

	// Memories
	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] loc_mem [LOCAL_COUNT];

	state_t state_q, state_d;
	logic [SPW-1:0] sp_q, sp_d;
	logic [31:0] arg_q [4];
	logic [4:0]  kind_q;
	logic [31:0] imm_q;
	logic [31:0] b_q, res_q;
	logic [2:0]  err_q;
	logic        clr_q;
	logic [LAW:0] clr_cnt_q;

	// Memory ports
	logic           s_re, s_we;
	logic [SAW-1:0] s_ra, s_wa;
	logic [31:0]    s_rd, s_wd;
	logic           l_re, l_we;
	logic [LAW-1:0] l_ra, l_wa;
	logic [31:0]    l_rd, l_wd;

	always_ff @(posedge clk) begin
		if (s_we) stk_mem[s_wa] <= s_wd;
		if (s_re) s_rd <= stk_mem[s_ra];
	end

	always_ff @(posedge clk) begin
		if (l_we) loc_mem[l_wa] <= l_wd;
		if (l_re) l_rd <= loc_mem[l_ra];
	end

	// Decode
	logic imm_pos;
	logic idx_arg_ok, idx_loc_ok;
	logic is_bin, is_un;
	always_comb begin
		imm_pos    = ~imm_q[31];
		idx_arg_ok = imm_pos && (imm_q < 32'(ARG_COUNT));
		idx_loc_ok = imm_pos && (imm_q < 32'(LOCAL_COUNT));
		is_bin = (kind_q >= K_ADD) && (kind_q <= K_GE) && (kind_q != K_NEG)
			&& (kind_q != K_BITNOT) && (kind_q != K_LOGNOT);
		is_un = (kind_q == K_NEG) || (kind_q == K_BITNOT) || (kind_q == K_LOGNOT);
	end

	// Error check on captured state
	logic [2:0] err_c;
	always_comb begin
		err_c = ERR_OK;
		case (kind_q)
			K_PUSHC: if (sp_q >= SPW'(STACK_DEPTH)) err_c = ERR_OVER;
			K_LDARG: begin
				if (!idx_arg_ok) err_c = ERR_INDEX;
				else if (sp_q >= SPW'(STACK_DEPTH)) err_c = ERR_OVER;
			end
			K_LDLOC: begin
				if (!idx_loc_ok) err_c = ERR_INDEX;
				else if (sp_q >= SPW'(STACK_DEPTH)) err_c = ERR_OVER;
			end
			K_STLOC: begin
				if (sp_q < SPW'(1)) err_c = ERR_UNDER;
				else if (!idx_loc_ok) err_c = ERR_INDEX;
			end
			default: begin
				if (is_un && sp_q < SPW'(1)) err_c = ERR_UNDER;
				else if (is_bin && sp_q < SPW'(2)) err_c = ERR_UNDER;
			end
		endcase
	end

	// Signed compare and simple results; lhs is the word below top, in s_rd
	logic slt_ab, slt_ba;
	logic [31:0] alu_c;
	logic [31:0] prod;
	always_comb begin
		slt_ab = $signed(s_rd) < $signed(b_q);
		slt_ba = $signed(b_q) < $signed(s_rd);
		prod   = s_rd * b_q;
		case (kind_q)
			K_ADD:    alu_c = s_rd + b_q;
			K_SUB:    alu_c = s_rd - b_q;
			K_MUL:    alu_c = prod;
			K_AND:    alu_c = s_rd & b_q;
			K_OR:     alu_c = s_rd | b_q;
			K_XOR:    alu_c = s_rd ^ b_q;
			K_EQ:     alu_c = {31'd0, s_rd == b_q};
			K_NE:     alu_c = {31'd0, s_rd != b_q};
			K_LT:     alu_c = {31'd0, slt_ab};
			K_LE:     alu_c = {31'd0, !slt_ba};
			K_GT:     alu_c = {31'd0, slt_ba};
			K_GE:     alu_c = {31'd0, !slt_ab};
			K_NEG:    alu_c = 32'd0 - b_q;
			K_BITNOT: alu_c = ~b_q;
			K_LOGNOT: alu_c = {31'd0, b_q == 32'd0};
			default:  alu_c = b_q;
		endcase
	end

	// Radix-2 divider on magnitudes
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0]  dcnt_q;
	logic        dna_q, dnb_q;
	logic [32:0] dtrial;
	always_comb dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	// Operand phase: top lands in s_rd first, then the word below it
	logic [1:0] rd_ph_q;

	// Controller
	always_comb begin
		state_d = state_q;
		sp_d = sp_q;
		s_re = 1'b0; s_ra = '0;
		s_we = 1'b0; s_wa = '0; s_wd = res_q;
		l_re = 1'b0; l_ra = imm_q[LAW-1:0];
		l_we = 1'b0; l_wa = imm_q[LAW-1:0]; l_wd = b_q;
		done = 1'b0;
		busy = (state_q != ST_IDLE) || clr_q;
		if (clr_q) begin
			l_we = 1'b1;
			l_wa = clr_cnt_q[LAW-1:0];
			l_wd = '0;
		end
		unique case (state_q)
			ST_IDLE: if (start && !clr_q) state_d = ST_READ;
			ST_READ: begin
				// fetch top entry and local entry
				s_re = 1'b1;
				s_ra = SAW'(sp_q - SPW'(1));
				l_re = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (rd_ph_q == 2'd0) begin
					// top now in s_rd; fetch the one below
					s_re = 1'b1;
					s_ra = SAW'(sp_q - SPW'(2));
				end else if (err_c != ERR_OK) begin
					state_d = ST_TOP;
				end else if ((kind_q == K_DIV || kind_q == K_MOD) && b_q == 32'd0) begin
					state_d = ST_TOP;
				end else if (kind_q == K_DIV || kind_q == K_MOD) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DIV: if (dcnt_q == 6'd32) state_d = ST_WRITE;
			ST_WRITE: begin
				case (kind_q)
					K_PUSHC, K_LDARG, K_LDLOC: begin
						s_we = 1'b1; s_wa = SAW'(sp_q); sp_d = sp_q + SPW'(1);
					end
					K_STLOC: begin
						l_we = 1'b1; sp_d = sp_q - SPW'(1);
					end
					default: begin
						if (is_un) begin
							s_we = 1'b1; s_wa = SAW'(sp_q - SPW'(1));
						end else if (is_bin) begin
							s_we = 1'b1; s_wa = SAW'(sp_q - SPW'(2));
							sp_d = sp_q - SPW'(1);
						end
					end
				endcase
				state_d = ST_TOP;
			end
			ST_TOP: state_d = ST_DONE;
			ST_DONE: begin
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sp_q      <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			rd_ph_q   <= '0;
			for (int i = 0; i < 4; i++) arg_q[i] <= '0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + (LAW+1)'(1);
				if (clr_cnt_q == (LAW+1)'(LOCAL_COUNT - 1)) clr_q <= 1'b0;
			end
			if (cfg_we && (32'(cfg_index) < 32'(NARG))) arg_q[cfg_index] <= cfg_data;
			if (state_q == ST_EXEC) rd_ph_q <= rd_ph_q + 2'd1;
			else rd_ph_q <= '0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			kind_q <= kind;
			imm_q  <= immediate;
		end
		if (state_q == ST_EXEC && rd_ph_q == 2'd0) begin
			b_q <= (kind_q == K_PUSHC) ? imm_q
				: (kind_q == K_LDARG) ? arg_q[imm_q[1:0]]
				: (kind_q == K_LDLOC) ? l_rd : s_rd;
		end
		if (state_q == ST_EXEC && rd_ph_q == 2'd1) begin
			err_q <= ((kind_q == K_DIV || kind_q == K_MOD) && err_c == ERR_OK
				&& b_q == 32'd0) ? ERR_DIV0 : err_c;
			// argument slots past the register list read zero
			res_q <= (kind_q == K_LDARG && imm_q >= 32'(NARG)) ? 32'd0 : alu_c;
			dna_q <= s_rd[31];
			dnb_q <= b_q[31];
			dq_q  <= s_rd[31] ? 32'd0 - s_rd : s_rd;
			dd_q  <= b_q[31] ? 32'd0 - b_q : b_q;
			dr_q  <= '0;
			dcnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (dcnt_q != 6'd32) begin
				if (!dtrial[32]) begin
					dr_q <= dtrial[31:0];
					dq_q <= {dq_q[30:0], 1'b1};
				end else begin
					dr_q <= {dr_q[30:0], dq_q[31]};
					dq_q <= {dq_q[30:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 6'd1;
			end else if (kind_q == K_DIV) begin
				res_q <= (dna_q != dnb_q) ? 32'd0 - dq_q : dq_q;
			end else begin
				res_q <= dna_q ? 32'd0 - dr_q : dr_q;
			end
		end
	end

	// Top read for result: stack word read in ST_TOP after the update
	logic [31:0] top_mem_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_TOP) top_mem_q <= stk_mem[SAW'(sp_q - SPW'(1))];
	end

	always_comb begin
		top_value   = (sp_q == '0) ? 32'sd0 : $signed(top_mem_q);
		stack_depth = 5'(sp_q);
		error_code  = err_q;
	end

`ifndef ASSERT_OFF
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
	a_sp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_OK && done) |-> $stable(sp_q)) else $error("fault moved sp");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the int32 stack machine executor
// Drives directed and random instruction streams, predicts each result with
// a scoreboard model of stack, locals and argument words, and compares.
// ----------------------------------------------------------------------------
import smi_pkg::*;

class exec_scoreboard;
	logic [31:0] stk [16];
	logic [4:0]  sp;
	logic [31:0] locals [16];
	logic [31:0] args [4];
	logic [31:0] exp_top [$];
	logic [4:0]  exp_depth [$];
	logic [2:0]  exp_err [$];
	int          errors;

	function new();
		sp = 0;
		errors = 0;
		foreach (stk[i]) stk[i] = 0;
		foreach (locals[i]) locals[i] = 0;
		foreach (args[i]) args[i] = 0;
	endfunction

	function void set_arg(int idx, logic [31:0] v);
		args[idx] = v;
	endfunction

	function logic [31:0] quot_rem(logic [31:0] a, logic [31:0] b, bit want_rem);
		logic [31:0] ma, mb, q, r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_rem) return a[31] ? -r : r;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function logic [2:0] execute(logic [4:0] k, logic [31:0] imm);
		logic [31:0] a, b, v;
		case (k)
			K_PUSHC: begin
				if (sp >= 16) return ERR_OVER;
				stk[sp] = imm; sp++;
			end
			K_LDARG, K_LDLOC: begin
				if (imm[31] || imm >= ((k == K_LDARG) ? 4 : 16)) return ERR_INDEX;
				if (sp >= 16) return ERR_OVER;
				stk[sp] = (k == K_LDARG) ? args[imm[1:0]] : locals[imm[3:0]];
				sp++;
			end
			K_STLOC: begin
				if (sp < 1) return ERR_UNDER;
				if (imm[31] || imm >= 16) return ERR_INDEX;
				locals[imm[3:0]] = stk[sp-1]; sp--;
			end
			K_NEG, K_BITNOT, K_LOGNOT: begin
				if (sp < 1) return ERR_UNDER;
				v = stk[sp-1];
				stk[sp-1] = (k == K_NEG) ? -v : (k == K_BITNOT) ? ~v : {31'd0, v == 0};
			end
			default: begin
				if (k < K_ADD || k > K_GE) return ERR_OK;
				if (sp < 2) return ERR_UNDER;
				b = stk[sp-1];
				a = stk[sp-2];
				if ((k == K_DIV || k == K_MOD) && b == 0) return ERR_DIV0;
				case (k)
					K_ADD: v = a + b;
					K_SUB: v = a - b;
					K_MUL: v = a * b;
					K_DIV: v = quot_rem(a, b, 0);
					K_MOD: v = quot_rem(a, b, 1);
					K_AND: v = a & b;
					K_OR:  v = a | b;
					K_XOR: v = a ^ b;
					K_EQ:  v = a == b;
					K_NE:  v = a != b;
					K_LT:  v = $signed(a) < $signed(b);
					K_LE:  v = $signed(a) <= $signed(b);
					K_GT:  v = $signed(a) > $signed(b);
					default: v = $signed(a) >= $signed(b);
				endcase
				stk[sp-2] = v; sp--;
			end
		endcase
		return ERR_OK;
	endfunction

	// note an accepted transaction and queue its expected result
	function void note_instr(logic [4:0] k, logic [31:0] imm);
		logic [2:0] e;
		e = execute(k, imm);
		exp_err.push_back(e);
		exp_depth.push_back(sp);
		exp_top.push_back(sp > 0 ? stk[sp-1] : 32'd0);
	endfunction

	function void check_result(logic [31:0] top, logic [4:0] depth, logic [2:0] err);
		if (exp_err.size() == 0) begin
			$display("%0t: unexpected result top=%h depth=%0d err=%0d", $time, top, depth, err);
			errors++;
			return;
		end
		if (exp_top[0] !== top) begin
			$display("%0t: top_value exp %h got %h", $time, exp_top[0], top);
			errors++;
		end
		if (exp_depth[0] !== depth) begin
			$display("%0t: stack_depth exp %0d got %0d", $time, exp_depth[0], depth);
			errors++;
		end
		if (exp_err[0] !== err) begin
			$display("%0t: error_code exp %0d got %0d", $time, exp_err[0], err);
			errors++;
		end
		void'(exp_top.pop_front());
		void'(exp_depth.pop_front());
		void'(exp_err.pop_front());
	endfunction

	function int pending();
		return exp_err.size();
	endfunction
endclass

module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [4:0]  kind = 0;
	logic signed [31:0] immediate = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	wire         busy, done;
	wire signed [31:0] top_value;
	wire [4:0]   stack_depth;
	wire [2:0]   error_code;

	exec_scoreboard sb = new();

	stack_machine_int32_executor_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.immediate(immediate), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .top_value(top_value),
		.stack_depth(stack_depth), .error_code(error_code)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(top_value, stack_depth, error_code);
	end

	// run limit
	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(negedge clk);
	endtask

	// issue one instruction; leaves start high at the accepting edge
	task automatic issue(logic [4:0] k, logic [31:0] imm);
		@(negedge clk);
		kind <= k;
		immediate <= imm;
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_instr(k, imm);
		@(negedge clk);
		start <= 0;
	endtask

	task automatic drain();
		while (sb.pending() > 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_arg(int idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx[1:0];
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_arg(idx, v);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_index(int count);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return -$urandom_range(1, 3);
			2: return count + $urandom_range(0, 2);
			default: return $urandom_range(0, count - 1);
		endcase
	endfunction

	initial begin
		int k;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		for (int i = 0; i < 4; i++) write_arg(i, rand_value());

		// directed: underflow, extremes, division corner cases, bad index, unknown kind, overflow
		issue(K_ADD, 0);
		issue(K_STLOC, 0);
		issue(K_NEG, 0);
		issue(K_LDLOC, 5);
		issue(K_PUSHC, 32'h8000_0000);
		issue(K_PUSHC, 32'hffff_ffff);
		issue(K_DIV, 0);
		issue(K_PUSHC, 32'h8000_0000);
		issue(K_PUSHC, 32'hffff_ffff);
		issue(K_MOD, 0);
		issue(K_PUSHC, 0);
		issue(K_DIV, 0);
		issue(K_MOD, 0);
		issue(K_LDARG, 4);
		issue(K_LDARG, 32'hffff_ffff);
		issue(K_LDLOC, 16);
		issue(K_STLOC, 32'h8000_0000);
		issue(K_STLOC, 15);
		issue(K_LDARG, 3);
		issue(K_BITNOT, 0);
		issue(K_LOGNOT, 0);
		issue(5'd31, 32'h7fff_ffff);
		for (int i = 0; i < 18; i++) issue(K_PUSHC, i);
		issue(K_LDLOC, 15);
		issue(K_LDARG, 0);
		drain();

		// random phases with new argument words between them
		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 4; i++)
				write_arg(i, (ph == 1) ? 32'h8000_0000 : (ph == 2) ? 32'h7fff_ffff : rand_value());
			for (int n = 0; n < 100; n++) begin
				idle_gap();
				if (sb.sp < 3 && $urandom_range(0, 2) != 0)
					k = $urandom_range(1, 3);
				else if (sb.sp > 13 && $urandom_range(0, 2) != 0)
					k = $urandom_range(4, 21);
				else if ($urandom_range(0, 19) == 0)
					k = $urandom_range(0, 31);
				else
					k = $urandom_range(1, 21);
				if (k == K_PUSHC) issue(5'(k), rand_value());
				else if (k == K_LDARG) issue(5'(k), rand_index(4));
				else if (k >= K_LDLOC && k <= K_STLOC) issue(5'(k), rand_index(16));
				else issue(5'(k), $urandom);
				if (n == 50) drain();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
